[hdl/cdq_pkg.sv]
package cdq_pkg;

   // Field widths fixed by the interface
   localparam int unsigned CAPACITY_W = 8;
   localparam int unsigned OP_W       = 3;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned STATUS_W   = 2;

   // Default ring depth and capacity after reset
   localparam int unsigned DEFAULT_MAX_SLOTS = 128;
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 8'd128;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_REPORT     = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED     = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic update;   // apply the operation of the accepted transfer
      logic read;     // read front and rear slots
      logic load;     // move the result into the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free; // output register empty or being taken this cycle
   } ctl_stat_type;

endpackage

[hdl/cdq_req_if.sv]
interface cdq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [cdq_pkg::OP_W-1:0]               op;
   logic signed [cdq_pkg::VALUE_W-1:0]     value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

[hdl/cdq_rsp_if.sv]
interface cdq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cdq_pkg::VALUE_W-1:0]     front_value;
   logic signed [cdq_pkg::VALUE_W-1:0]     rear_value;
   logic                                   is_empty;
   logic [cdq_pkg::STATUS_W-1:0]           status;

   modport source (output valid, output front_value, output rear_value, output is_empty,
                   output status, input ready);
   modport sink   (input valid, input front_value, input rear_value, input is_empty,
                   input status, output ready);
endinterface

[hdl/circular_deque_unit.sv]
// Double-ended queue held in a ring store of MAX_SLOTS words, of which the
// capacity register (written through csr_write_enable / csr_write_data, reset
// 128, 0 acts as 1, values above MAX_SLOTS act as MAX_SLOTS) sets how many are
// in use. Each request transfer pushes a value at the front or rear, pops
// either end or only reports; each gives exactly one response with the front
// and rear values (zero when empty), an empty flag and a status that flags a
// refused push on a full deque or a refused pop on an empty one. One request
// is handled at a time and passes through these steps from transfer to response
// (update and write, registered read of both ends, load into the output
// register); a response that is not taken holds the unit in its last step,
// while the next request is taken as soon as the output register has been
// loaded. The store is not cleared at reset; only occupied slots are ever
// shown.
module circular_deque_unit #(
   parameter int unsigned MAX_SLOTS = cdq_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [cdq_pkg::CAPACITY_W-1:0]  csr_write_data,
   cdq_req_if.sink                         req_ch,
   cdq_rsp_if.source                       rsp_ch
);
   import cdq_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   cdq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_ch.op),
      .req_value        (req_ch.value),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_front_value  (rsp_ch.front_value),
      .rsp_rear_value   (rsp_ch.rear_value),
      .rsp_is_empty     (rsp_ch.is_empty),
      .rsp_status       (rsp_ch.status)
   );

   // One request at a time: no transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while previous one in flight");

   // An update is always followed by the read of both ends
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> cmd.read)
      else $error("read step skipped after update");

   // A load always presents a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_ch.valid)
      else $error("loaded response not presented");

   // An empty response carries zero values; every response has a defined status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_empty) |->
         (rsp_ch.front_value == '0) && (rsp_ch.rear_value == '0))
      else $error("empty response with nonzero values");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.status != STATUS_UNUSED))
      else $error("undefined status code");

endmodule

[hdl/cdq_controller.sv]
module cdq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdq_pkg::ctl_stat_type stat,
   output cdq_pkg::ctl_cmd_type  cmd
);
   import cdq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Decode commands and next state
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.update = 1'b0;
      cmd.read   = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.update = req_valid;
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.load = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/cdq_datapath.sv]
module cdq_datapath #(
   parameter int unsigned MAX_SLOTS = cdq_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [cdq_pkg::CAPACITY_W-1:0]      csr_write_data,
   input  cdq_pkg::ctl_cmd_type                cmd,
   output cdq_pkg::ctl_stat_type               stat,
   input  logic [cdq_pkg::OP_W-1:0]            req_op,
   input  logic signed [cdq_pkg::VALUE_W-1:0]  req_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [cdq_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic signed [cdq_pkg::VALUE_W-1:0]  rsp_rear_value,
   output logic                                rsp_is_empty,
   output logic [cdq_pkg::STATUS_W-1:0]        rsp_status
);
   import cdq_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
   localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int unsigned CMP_W = (CNT_W > CAPACITY_W) ? CNT_W : CAPACITY_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SLOTS);

   logic [CAPACITY_W-1:0] capacity_ff;
   logic [IDX_W-1:0]      front_ff, front_in;
   logic [IDX_W-1:0]      rear_ff, rear_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic [VALUE_W-1:0]    ring_mem [MAX_SLOTS];
   logic [VALUE_W-1:0]    front_rd_ff, rear_rd_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;

   logic                  out_valid_ff;
   logic [VALUE_W-1:0]    out_front_ff, out_rear_ff;
   logic                  out_empty_ff;
   logic [STATUS_W-1:0]   out_status_ff;

   logic [CMP_W-1:0]      cap_raw, eff_cap, cap_m1, count_cmp;
   logic [IDX_W-1:0]      front_up, front_down, rear_up, rear_down;
   logic                  is_push, is_pop, full, empty;

   // Hold the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   // Clamp capacity to the usable range
   always_comb begin
      cap_raw = CMP_W'(capacity_ff);
      if (cap_raw == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_raw > MAX_CMP) begin
         eff_cap = MAX_CMP;
      end else begin
         eff_cap = cap_raw;
      end
      cap_m1    = eff_cap - CMP_W'(1);
      count_cmp = CMP_W'(count_ff);
   end

   // Wrap the index steps at the capacity
   always_comb begin
      front_up   = (CMP_W'(front_ff) >= cap_m1) ? '0 : front_ff + IDX_W'(1);
      rear_up    = (CMP_W'(rear_ff) >= cap_m1) ? '0 : rear_ff + IDX_W'(1);
      front_down = (front_ff == '0) ? IDX_W'(cap_m1) : front_ff - IDX_W'(1);
      rear_down  = (rear_ff == '0) ? IDX_W'(cap_m1) : rear_ff - IDX_W'(1);
   end

   // Apply one operation to indices and count
   always_comb begin
      is_push   = (req_op == OP_PUSH_FRONT) || (req_op == OP_PUSH_REAR);
      is_pop    = (req_op == OP_POP_FRONT) || (req_op == OP_POP_REAR);
      full      = count_cmp >= eff_cap;
      empty     = count_ff == '0;
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      if (is_push) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
            if (empty) begin
               front_in = '0;
               rear_in  = '0;
               wr_addr  = '0;
            end else if (req_op == OP_PUSH_FRONT) begin
               front_in = front_down;
               wr_addr  = front_down;
            end else begin
               rear_in = rear_up;
               wr_addr = rear_up;
            end
         end
      end else if (is_pop) begin
         if (empty) begin
            status_in = STATUS_EMPTY;
         end else if (count_ff == CNT_W'(1)) begin
            count_in = '0;
            front_in = '0;
            rear_in  = '0;
         end else begin
            count_in = count_ff - CNT_W'(1);
            if (req_op == OP_POP_FRONT) begin
               front_in = front_up;
            end else begin
               rear_in = rear_down;
            end
         end
      end
   end

   // Update the ends and the count on a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         status_ff <= status_in;
      end
   end

   // Ring store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.update && wr_en) begin
         ring_mem[wr_addr] <= req_value;
      end
      if (cmd.read) begin
         front_rd_ff <= ring_mem[front_ff];
         rear_rd_ff  <= ring_mem[rear_ff];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_front_ff  <= empty ? '0 : front_rd_ff;
         out_rear_ff   <= empty ? '0 : rear_rd_ff;
         out_empty_ff  <= empty;
         out_status_ff <= status_ff;
      end
   end

   assign stat.out_free   = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_front_value = out_front_ff;
   assign rsp_rear_value  = out_rear_ff;
   assign rsp_is_empty    = out_empty_ff;
   assign rsp_status      = out_status_ff;

endmodule

[dv/tb.sv]
module tb;
   import cdq_pkg::*;

   localparam int unsigned MAX_SLOTS   = DEFAULT_MAX_SLOTS;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_OPS  = 650;
   localparam int unsigned HOLD_AT     = 150;
   localparam int unsigned LONG_HOLD   = 90;
   localparam int unsigned DRAIN_WAIT  = 8;
   localparam int unsigned HOLD_BACKLOG = 8;

   // Op codes outside the defined set; the unit treats them as report only
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   // Copy of the deque state used while building stimulus, and the one used
   // for checking at transfer time
   localparam int PLAN_COPY  = 0;
   localparam int CHECK_COPY = 1;

   typedef enum logic [1:0] {
      SINK_FLOW,
      SINK_RANDOM,
      SINK_PERIODIC
   } sink_mode_type;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
   } deque_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] rear_value;
      logic                      is_empty;
      logic [STATUS_W-1:0]       status;
   } deque_view_type;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CAPACITY_W-1:0] csr_write_data   = '0;

   logic                      drv_valid  = 1'b0;
   logic [OP_W-1:0]           drv_op     = '0;
   logic signed [VALUE_W-1:0] drv_value  = '0;
   logic                      sink_ready = 1'b0;
   logic                      req_fire   = 1'b0;

   deque_req_type  op_backlog[$];
   deque_view_type predicted_views[$];

   int unsigned items_queued   = 0;
   int unsigned items_accepted = 0;
   int unsigned fail_count     = 0;

   // Deque state, two copies
   logic signed [VALUE_W-1:0] slot_data [2][MAX_SLOTS];
   bit                        slot_written [2][MAX_SLOTS];
   int unsigned               front_at [2];
   int unsigned               rear_at [2];
   int unsigned               held [2];
   int unsigned               cap_reg [2];

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   assign req_ch.valid = drv_valid;
   assign req_ch.op    = drv_op;
   assign req_ch.value = drv_value;
   assign rsp_ch.ready = sink_ready;

   circular_deque_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one operation to a copy of the deque. Returns 0 when the view after
   // the operation would show a slot that was never written; state changes
   // only when commit is set.
   function automatic bit step_deque(input int m, input logic [OP_W-1:0] op,
                                     input logic signed [VALUE_W-1:0] value,
                                     input bit commit, output deque_view_type view);
      int unsigned cap, fi, ri, cnt, slot;
      bit          writes, shown_ok;
      cap    = (cap_reg[m] == 0) ? 1 : ((cap_reg[m] > MAX_SLOTS) ? MAX_SLOTS : cap_reg[m]);
      fi     = front_at[m];
      ri     = rear_at[m];
      cnt    = held[m];
      writes = 1'b0;
      slot   = 0;
      view.status = STATUS_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
         if (cnt >= cap) begin
            view.status = STATUS_FULL;
         end else begin
            if (cnt == 0) begin
               fi = 0;
               ri = 0;
            end else if (op == OP_PUSH_FRONT) begin
               fi = (fi == 0) ? cap - 1 : fi - 1;
            end else begin
               ri = (ri >= cap - 1) ? 0 : ri + 1;
            end
            slot   = (op == OP_PUSH_FRONT) ? fi : ri;
            writes = 1'b1;
            cnt++;
         end
      end else if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
         if (cnt == 0) begin
            view.status = STATUS_EMPTY;
         end else if (cnt == 1) begin
            cnt = 0;
            fi  = 0;
            ri  = 0;
         end else begin
            if (op == OP_POP_FRONT)
               fi = (fi >= cap - 1) ? 0 : fi + 1;
            else
               ri = (ri == 0) ? cap - 1 : ri - 1;
            cnt--;
         end
      end
      fi = fi % MAX_SLOTS;
      ri = ri % MAX_SLOTS;
      shown_ok = (cnt == 0) ||
                 ((slot_written[m][fi] || (writes && slot == fi)) &&
                  (slot_written[m][ri] || (writes && slot == ri)));
      if (commit) begin
         if (writes) begin
            slot_data[m][slot]    = value;
            slot_written[m][slot] = 1'b1;
         end
         front_at[m] = fi;
         rear_at[m]  = ri;
         held[m]     = cnt;
      end
      if (cnt == 0) begin
         view.front_value = '0;
         view.rear_value  = '0;
         view.is_empty    = 1'b1;
      end else begin
         view.front_value = slot_data[m][fi];
         view.rear_value  = slot_data[m][ri];
         view.is_empty    = 1'b0;
      end
      return shown_ok;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(15, 0))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int unsigned push_pct);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 4)
         return OP_W'($urandom_range(OP_SPARE_7, OP_SPARE_5));
      if (roll < 12)
         return OP_REPORT;
      if ($urandom_range(99, 0) < push_pct)
         return ($urandom_range(1, 0) == 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      return ($urandom_range(1, 0) == 1) ? OP_POP_REAR : OP_POP_FRONT;
   endfunction

   // Plan one request; swap in a report where the op would expose an unwritten slot
   task automatic queue_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
      deque_view_type scratch;
      deque_req_type  item;
      item.op    = op;
      item.value = value;
      if (!step_deque(PLAN_COPY, op, value, 1'b0, scratch))
         item.op = OP_REPORT;
      void'(step_deque(PLAN_COPY, item.op, value, 1'b1, scratch));
      op_backlog.push_back(item);
      items_queued++;
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (items_accepted != items_queued || predicted_views.size() != 0);
   endtask

   task automatic write_capacity(input logic [CAPACITY_W-1:0] cap);
      wait_idle();
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_write_data   <= cap;
      csr_write_enable <= 1'b1;
      cap_reg[PLAN_COPY]  = 32'(cap);
      cap_reg[CHECK_COPY] = 32'(cap);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Request driver: bursts of random length, random gaps, hold until transfer
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin
      bit offer;
      offer = 1'b0;
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (req_fire)
            op_backlog.delete(0);
         if (!drv_valid || req_fire) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (op_backlog.size() != 0) begin
               offer = 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(40, 1);
                  gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(9, 1);
               end
            end
            drv_valid <= offer;
            if (offer) begin
               drv_op    <= op_backlog[0].op;
               drv_value <= op_backlog[0].value;
            end
         end
      end
   end

   // Response sink: stall pattern per segment, plus one long hold-off
   sink_mode_type sink_mode   = SINK_FLOW;
   int unsigned   seg_left    = 0;
   int unsigned   pattern_len = 2;
   int unsigned   pattern_pos = 0;
   int unsigned   hold_left   = 0;
   bit            hold_done   = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         sink_ready <= 1'b0;
      end else if (!hold_done && items_accepted >= HOLD_AT &&
                   op_backlog.size() > HOLD_BACKLOG) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         sink_ready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_left    = $urandom_range(80, 16);
            sink_mode   = sink_mode_type'($urandom_range(2, 0));
            pattern_len = $urandom_range(6, 2);
            pattern_pos = 0;
         end else begin
            seg_left--;
         end
         case (sink_mode)
            SINK_RANDOM:   sink_ready <= ($urandom_range(99, 0) >= 35);
            SINK_PERIODIC: begin
               sink_ready <= (pattern_pos != 0);
               pattern_pos = (pattern_pos + 1) % pattern_len;
            end
            default:       sink_ready <= 1'b1;
         endcase
      end
   end

   // Predict on request transfer, compare on response transfer
   always @(posedge clock) begin
      deque_view_type view, want;
      req_fire <= !reset && drv_valid && (req_ch.ready === 1'b1);
      if (!reset) begin
         if (drv_valid && req_ch.ready === 1'b1) begin
            void'(step_deque(CHECK_COPY, req_ch.op, req_ch.value, 1'b1, view));
            predicted_views.push_back(view);
            items_accepted++;
         end
         if (rsp_ch.valid === 1'b1 && sink_ready) begin
            if (predicted_views.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = predicted_views[0];
               predicted_views.delete(0);
               if (rsp_ch.front_value !== want.front_value) begin
                  $error("front_value: expected %0d, got %0d", want.front_value,
                         rsp_ch.front_value);
                  fail_count++;
               end
               if (rsp_ch.rear_value !== want.rear_value) begin
                  $error("rear_value: expected %0d, got %0d", want.rear_value,
                         rsp_ch.rear_value);
                  fail_count++;
               end
               if (rsp_ch.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
                  fail_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog
   initial begin
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [CAPACITY_W-1:0] cap_plan [13];
      int unsigned           random_queued, phase_no, n_items, push_pct, k;
      logic [CAPACITY_W-1:0] cap;
      cap_plan = '{8'd1, 8'd2, 8'd0, 8'd3, 8'd255, 8'd5, 8'd129, 8'd128, 8'd16, 8'd4,
                   8'd64, 8'd7, 8'd127};
      random_queued = 0;
      phase_no      = 0;
      for (int m = 0; m < 2; m++) begin
         front_at[m] = 0;
         rear_at[m]  = 0;
         held[m]     = 0;
         cap_reg[m]  = 32'(CAPACITY_RESET);
         for (int s = 0; s < MAX_SLOTS; s++) begin
            slot_data[m][s]    = '0;
            slot_written[m][s] = 1'b0;
         end
      end

      // Hold reset at the start, then release it
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty refusals, extreme values, spare op codes, last-entry pops
      queue_op(OP_REPORT, 32'sd0);
      queue_op(OP_POP_FRONT, 32'sd0);
      queue_op(OP_POP_REAR, 32'sd0);
      queue_op(OP_PUSH_FRONT, 32'sh8000_0000);
      queue_op(OP_PUSH_REAR, 32'sh7fff_ffff);
      queue_op(OP_REPORT, 32'sd0);
      queue_op(OP_SPARE_5, 32'sd1);
      queue_op(OP_SPARE_7, -32'sd1);
      queue_op(OP_PUSH_FRONT, 32'sd0);
      queue_op(OP_PUSH_REAR, -32'sd1);
      queue_op(OP_POP_FRONT, 32'sd0);
      queue_op(OP_POP_REAR, 32'sd0);
      queue_op(OP_POP_FRONT, 32'sd0);
      queue_op(OP_POP_REAR, 32'sd0);
      queue_op(OP_POP_REAR, 32'sd0);

      // Capacity of one: full after a single push
      write_capacity(8'd1);
      queue_op(OP_PUSH_REAR, 32'sh1234_5678);
      queue_op(OP_PUSH_FRONT, 32'sh0bad_cafe);
      queue_op(OP_SPARE_6, 32'sd0);
      queue_op(OP_POP_FRONT, 32'sd0);

      // Capacity of two: wrap both ends
      write_capacity(8'd2);
      queue_op(OP_PUSH_FRONT, 32'sd11);
      queue_op(OP_PUSH_FRONT, 32'sd22);
      queue_op(OP_PUSH_REAR, 32'sd33);
      queue_op(OP_POP_REAR, 32'sd0);
      queue_op(OP_PUSH_REAR, 32'sd44);

      // Random phases; entries stay held across capacity changes
      while (random_queued < RANDOM_OPS) begin
         if (phase_no < 13)
            cap = cap_plan[phase_no];
         else if ($urandom_range(3, 0) == 0)
            cap = CAPACITY_W'($urandom_range(255, 0));
         else
            cap = CAPACITY_W'($urandom_range(12, 1));
         write_capacity(cap);
         if (phase_no == 4) begin
            // Fill to the largest capacity and push past it
            for (k = 0; k < 140; k++)
               queue_op(($urandom_range(1, 0) == 1) ? OP_PUSH_REAR : OP_PUSH_FRONT,
                        pick_value());
            random_queued += 140;
         end else begin
            n_items = $urandom_range(60, 20);
            case ($urandom_range(2, 0))
               0:       push_pct = 30;
               1:       push_pct = 50;
               default: push_pct = 72;
            endcase
            for (k = 0; k < n_items; k++)
               queue_op(pick_op(push_pct), pick_value());
            random_queued += n_items;
         end
         phase_no++;
      end

      // Drain and let the pipeline settle
      wait_idle();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[circular_deque_unit.f]
hdl/cdq_pkg.sv
hdl/cdq_req_if.sv
hdl/cdq_rsp_if.sv
hdl/cdq_controller.sv
hdl/cdq_datapath.sv
hdl/circular_deque_unit.sv
dv/tb.sv
